/* src/fckl_pkg.sv */
// Shared types and codes for the fixed-capacity keyed list.
package fckl_pkg;

  // Field widths of the stream words
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int POS_W    = 4;
  localparam int ST_W     = 3;
  localparam int CNT_W    = 5;
  localparam int TDATA_W  = 72;

  // Operation codes carried in in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_INS_TAIL   = 3'd0,
    OP_INS_HEAD   = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_RM_TAIL    = 3'd3,
    OP_RM_HEAD    = 3'd4,
    OP_RM_KEY     = 3'd5,
    OP_LOOKUP     = 3'd6,
    OP_READ_AT    = 3'd7
  } op_t;

  // Result status codes carried in out_tuser
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOKEY = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_OPEN_RD,
    S_OPEN_WR,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_READ,
    S_DONE
  } state_t;

  // Read address select (logical index relative to head)
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_POS
  } rd_sel_t;

  // Write address select
  typedef enum logic [1:0] {
    WA_IDX,
    WA_COUNT,
    WA_HEAD_M1
  } wa_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_in;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    open_start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    logic    wr_move;
    logic    head_inc;
    logic    head_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_t res_status;
    logic    res_found;
    logic    out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic idx_at_count;
    logic idx_at_gap;
    logic idx_last;
    logic pos_oob;
    logic key_less;
    logic key_eq;
    logic out_free;
  } sts_t;

endpackage

/* src/fckl_ctrl.sv */
// Controller state machine for the keyed list: sequences scans and entry moves.
module fckl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  fckl_pkg::sts_t  sts,
  output fckl_pkg::cmd_t  cmd
);

  fckl_pkg::state_t state_r;
  fckl_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fckl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = fckl_pkg::RD_IDX;
    cmd.wa_sel = fckl_pkg::WA_IDX;
    cmd.res_status = fckl_pkg::ST_OK;
    in_tready  = 1'b0;

    unique case (state_r)
      fckl_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = fckl_pkg::S_EXEC;
        end
      end

      fckl_pkg::S_EXEC: begin
        state_nxt = fckl_pkg::S_DONE;
        unique case (sts.op) inside
          fckl_pkg::OP_INS_TAIL: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_status = fckl_pkg::ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = fckl_pkg::WA_COUNT;
              cmd.cnt_inc = 1'b1;
            end
          end
          fckl_pkg::OP_INS_HEAD: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_status = fckl_pkg::ST_FULL;
            end else begin
              cmd.wr_en    = 1'b1;
              cmd.wa_sel   = fckl_pkg::WA_HEAD_M1;
              cmd.head_dec = 1'b1;
              cmd.cnt_inc  = 1'b1;
            end
          end
          fckl_pkg::OP_INS_SORTED: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = fckl_pkg::ST_FULL;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = fckl_pkg::S_SCAN_RD;
            end
          end
          fckl_pkg::OP_RM_TAIL: begin
            cmd.res_load = 1'b1;
            if (sts.empty) begin
              cmd.res_status = fckl_pkg::ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          fckl_pkg::OP_RM_HEAD: begin
            cmd.res_load = 1'b1;
            if (sts.empty) begin
              cmd.res_status = fckl_pkg::ST_EMPTY;
            end else begin
              cmd.head_inc = 1'b1;
              cmd.cnt_dec  = 1'b1;
            end
          end
          fckl_pkg::OP_RM_KEY, fckl_pkg::OP_LOOKUP: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = fckl_pkg::ST_EMPTY;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = fckl_pkg::S_SCAN_RD;
            end
          end
          fckl_pkg::OP_READ_AT: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = fckl_pkg::ST_EMPTY;
            end else if (sts.pos_oob) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = fckl_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = fckl_pkg::RD_POS;
              state_nxt  = fckl_pkg::S_READ;
            end
          end
          default: begin
            state_nxt = fckl_pkg::S_IDLE;
          end
        endcase
      end

      // Issue a read of the entry under the scan index, or end the scan
      fckl_pkg::S_SCAN_RD: begin
        if (sts.idx_at_count) begin
          if (sts.op == fckl_pkg::OP_INS_SORTED) begin
            cmd.open_start = 1'b1;
            state_nxt      = fckl_pkg::S_OPEN_RD;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = fckl_pkg::ST_NOKEY;
            state_nxt      = fckl_pkg::S_DONE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = fckl_pkg::RD_IDX;
          state_nxt  = fckl_pkg::S_SCAN_CMP;
        end
      end

      // Compare the entry just read
      fckl_pkg::S_SCAN_CMP: begin
        if (sts.op == fckl_pkg::OP_INS_SORTED) begin
          if (sts.key_less) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = fckl_pkg::S_SCAN_RD;
          end else begin
            cmd.open_start = 1'b1;
            state_nxt      = fckl_pkg::S_OPEN_RD;
          end
        end else if (sts.key_eq) begin
          if (sts.op == fckl_pkg::OP_LOOKUP) begin
            cmd.res_load  = 1'b1;
            cmd.res_found = 1'b1;
            state_nxt     = fckl_pkg::S_DONE;
          end else begin
            state_nxt = fckl_pkg::S_CLOSE_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = fckl_pkg::S_SCAN_RD;
        end
      end

      // Open a gap: move entries up one place from the tail down to the gap
      fckl_pkg::S_OPEN_RD: begin
        if (sts.idx_at_gap) begin
          cmd.wr_en    = 1'b1;
          cmd.wa_sel   = fckl_pkg::WA_IDX;
          cmd.cnt_inc  = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = fckl_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = fckl_pkg::RD_IDX_M1;
          state_nxt  = fckl_pkg::S_OPEN_WR;
        end
      end

      fckl_pkg::S_OPEN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = fckl_pkg::WA_IDX;
        cmd.wr_move = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = fckl_pkg::S_OPEN_RD;
      end

      // Close a gap: move entries down one place from the gap to the tail
      fckl_pkg::S_CLOSE_RD: begin
        if (sts.idx_last) begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = fckl_pkg::S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = fckl_pkg::RD_IDX_P1;
          state_nxt  = fckl_pkg::S_CLOSE_WR;
        end
      end

      fckl_pkg::S_CLOSE_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = fckl_pkg::WA_IDX;
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = fckl_pkg::S_CLOSE_RD;
      end

      // Positional read data is back
      fckl_pkg::S_READ: begin
        cmd.res_load  = 1'b1;
        cmd.res_found = 1'b1;
        state_nxt     = fckl_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free
      fckl_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fckl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fckl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/fckl_dp.sv */
// Datapath for the keyed list: entry memory as a ring, counters, compare and result registers.
module fckl_dp #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fckl_pkg::TDATA_W-1:0]  in_tdata,
  input  logic [fckl_pkg::OP_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fckl_pkg::TDATA_W-1:0]  out_tdata,
  output logic [fckl_pkg::ST_W-1:0]     out_tuser,
  input  fckl_pkg::cmd_t                cmd,
  output fckl_pkg::sts_t                sts
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SPB  = (PAYLOAD_BITS < fckl_pkg::PAY_W) ? PAYLOAD_BITS : fckl_pkg::PAY_W;
  localparam int CMPW = (CW > fckl_pkg::POS_W) ? CW : fckl_pkg::POS_W;
  localparam logic [CW:0]   CAP_X  = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  // Entry memory
  logic signed [fckl_pkg::KEY_W-1:0] mem_key [CAPACITY];
  logic        [SPB-1:0]             mem_pay [CAPACITY];

  // Latched input word
  fckl_pkg::op_t                      op_r;
  logic signed [fckl_pkg::KEY_W-1:0]  key_r;
  logic        [SPB-1:0]              pay_r;
  logic        [fckl_pkg::POS_W-1:0]  pos_r;

  // List bookkeeping
  logic [CW-1:0] count_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] gap_r;

  // Read data, result and output registers
  logic signed [fckl_pkg::KEY_W-1:0] rd_key_r;
  logic        [SPB-1:0]             rd_pay_r;
  fckl_pkg::status_t                 res_status_r;
  logic        [fckl_pkg::KEY_W-1:0] res_key_r;
  logic        [fckl_pkg::PAY_W-1:0] res_pay_r;
  logic                              out_valid_r;
  fckl_pkg::status_t                 out_status_r;
  logic        [fckl_pkg::KEY_W-1:0] out_key_r;
  logic        [fckl_pkg::PAY_W-1:0] out_pay_r;
  logic        [fckl_pkg::CNT_W-1:0] out_cnt_r;
  logic                              out_full_r;
  logic                              out_empty_r;

  logic [AW-1:0] phys_idx;
  logic [AW-1:0] phys_m1;
  logic [AW-1:0] phys_p1;
  logic [AW-1:0] phys_cnt;
  logic [AW-1:0] phys_pos;
  logic [AW-1:0] head_m1;
  logic [AW-1:0] head_p1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic signed [fckl_pkg::KEY_W-1:0] wr_key;
  logic        [SPB-1:0]             wr_pay;
  logic full;
  logic empty;
  logic out_free;

  // Logical offset from head to ring address (one compare and subtract)
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(ofs);
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return AW'(sum);
  endfunction

  // Ring addresses
  always_comb begin
    phys_idx = ring_addr(head_r, idx_r);
    phys_cnt = ring_addr(head_r, count_r);
    phys_pos = ring_addr(head_r, CW'(pos_r));
    phys_m1  = (phys_idx == '0) ? LAST_A : phys_idx - AW'(1);
    phys_p1  = (phys_idx == LAST_A) ? '0 : phys_idx + AW'(1);
    head_m1  = (head_r == '0) ? LAST_A : head_r - AW'(1);
    head_p1  = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  end

  // Port address and data selection
  always_comb begin
    case (cmd.rd_sel)
      fckl_pkg::RD_IDX_M1: rd_addr = phys_m1;
      fckl_pkg::RD_IDX_P1: rd_addr = phys_p1;
      fckl_pkg::RD_POS:    rd_addr = phys_pos;
      default:             rd_addr = phys_idx;
    endcase
    case (cmd.wa_sel)
      fckl_pkg::WA_COUNT:   wr_addr = phys_cnt;
      fckl_pkg::WA_HEAD_M1: wr_addr = head_m1;
      default:              wr_addr = phys_idx;
    endcase
    wr_key = cmd.wr_move ? rd_key_r : key_r;
    wr_pay = cmd.wr_move ? rd_pay_r : pay_r;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    if (cmd.rd_en) begin
      rd_key_r <= mem_key[rd_addr];
      rd_pay_r <= mem_pay[rd_addr];
    end
  end

  // Input word capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= fckl_pkg::op_t'(in_tuser);
      key_r <= in_tdata[fckl_pkg::KEY_W-1:0];
      pay_r <= in_tdata[fckl_pkg::KEY_W +: SPB];
      pos_r <= in_tdata[fckl_pkg::KEY_W + fckl_pkg::PAY_W +: fckl_pkg::POS_W];
    end
  end

  // Count, head and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      idx_r   <= '0;
      gap_r   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.head_inc) begin
        head_r <= head_p1;
      end else if (cmd.head_dec) begin
        head_r <= head_m1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.open_start) begin
        idx_r <= count_r;
        gap_r <= idx_r;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - CW'(1);
      end
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      if (cmd.res_found) begin
        res_key_r <= rd_key_r;
        res_pay_r <= fckl_pkg::PAY_W'(rd_pay_r);
      end else begin
        res_key_r <= '0;
        res_pay_r <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_pay_r    <= res_pay_r;
      out_cnt_r    <= fckl_pkg::CNT_W'(count_r);
      out_full_r   <= full;
      out_empty_r  <= empty;
    end
  end

  assign full     = (count_r == CAP_C);
  assign empty    = (count_r == '0);
  assign out_free = !out_valid_r || out_tready;

  // Status to the controller
  always_comb begin
    sts.op           = op_r;
    sts.empty        = empty;
    sts.full         = full;
    sts.idx_at_count = (idx_r == count_r);
    sts.idx_at_gap   = (idx_r == gap_r);
    sts.idx_last     = ((CW + 1)'(idx_r) + (CW + 1)'(1) == (CW + 1)'(count_r));
    sts.pos_oob      = (CMPW'(pos_r) >= CMPW'(count_r));
    sts.key_less     = (rd_key_r < key_r);
    sts.key_eq       = (rd_key_r == key_r);
    sts.out_free     = out_free;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_empty_r, out_full_r, out_cnt_r, out_pay_r, out_key_r};

endmodule

/* src/fixed_capacity_keyed_list_top.sv */
// Top level of the fixed-capacity keyed list: controller, datapath and checks.
//
//  port group  dir  tdata (low bit up)                              tuser
//  in_         in   key[31:0] payload[63:32] position[67:64]          op[2:0]
//  out_        out  found_key[31:0] found_payload[63:32]              status[2:0]
//                   entry_count[68:64] is_full[69] is_empty[70]
//
// One word is taken at a time; the next is accepted while the previous result
// still waits in the output register. Constant-time operations (tail and head
// insert and remove) go straight from execute to done; the entries live in a ring
// with a head pointer. Scans take a read and a compare state per entry visited,
// gap moves a read and a write state per entry moved, due to the single registered
// read port of the entry memory. Reset is synchronous, active low, and empties the
// list; a stalled output holds the finished word and the controller in its done state.
module fixed_capacity_keyed_list_top #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fckl_pkg::TDATA_W-1:0]  in_tdata,   // key, payload, position
  input  logic [fckl_pkg::OP_W-1:0]     in_tuser,   // op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fckl_pkg::TDATA_W-1:0]  out_tdata,  // found_key, found_payload, entry_count,
                                                    // is_full, is_empty
  output logic [fckl_pkg::ST_W-1:0]     out_tuser   // status
);

  fckl_pkg::cmd_t cmd;
  fckl_pkg::sts_t sts;

  fckl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fckl_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

`ifndef SYNTHESIS
  // No growth past capacity
  a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("count grows on a full list");

  // No shrink below zero
  a_no_dec_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.empty)
    else $error("count shrinks on an empty list");

  // One word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in progress");

  // Result never loaded over an unread word
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output word");
`endif

endmodule
